// File: hw/rtl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants for the decimal text converter
// Command/status structs between controller and datapath, widths, ASCII codes.
// ----------------------------------------------------------------------------
package sida_pkg;

    localparam int VALUE_W   = 33;                 // input integer width
    localparam int CHAR_W    = 8;                  // ASCII character width
    localparam int DIGITS    = 10;                 // max decimal digits of |value|
    localparam int BCD_W     = DIGITS * 4;
    localparam int STEP_BITS = 4;                  // binary bits consumed per cycle
    localparam int CONV_STEPS = (VALUE_W + STEP_BITS - 1) / STEP_BITS;
    localparam int BIN_W     = CONV_STEPS * STEP_BITS;
    localparam int IDX_W     = $clog2(DIGITS);
    localparam int CNT_W     = $clog2(CONV_STEPS);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture magnitude and sign
        logic conv;     // one shift-add-3 step group
        logic measure;  // locate most significant nonzero digit
        logic emit;     // put out one character
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;     // next emitted character ends the run
    } t_status;

endpackage

// File: hw/rtl/sida_ctrl.sv
// ----------------------------------------------------------------------------
// sida_ctrl: sequencing state machine
// Steps the datapath through load, conversion, digit count and emission.
// ----------------------------------------------------------------------------
module sida_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sida_pkg::t_status i_status,
    output sida_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_MEAS = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [sida_pkg::CNT_W-1:0] r_cnt, n_cnt;

    localparam logic [sida_pkg::CNT_W-1:0] CNT_LAST = sida_pkg::CNT_W'(sida_pkg::CONV_STEPS - 1);

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_MEAS;
                end
            end
            S_MEAS: begin
                o_cmd.measure = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTH
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_CONV))
        else $error("accepted start did not enter conversion");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_cnt <= CNT_LAST))
        else $error("conversion counter overran");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && i_status.last) |=> !busy)
        else $error("run ended but controller stayed busy");
`endif

endmodule

// File: hw/rtl/sida_dp.sv
// ----------------------------------------------------------------------------
// sida_dp: conversion datapath
// Magnitude, shift-add-3 binary to BCD (4 bits/cycle), digit emission.
// ----------------------------------------------------------------------------
module sida_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sida_pkg::t_cmd                i_cmd,
    input  logic [sida_pkg::VALUE_W-1:0]  i_value,
    output sida_pkg::t_status             o_status,
    output logic                          o_valid,
    output logic [sida_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last_char
);

    localparam int W = sida_pkg::BCD_W + sida_pkg::BIN_W;

    // four dependent shift-add-3 steps; nibbles within a step are independent
    function automatic logic [W-1:0] dd_step(input logic [W-1:0] w_in);
        logic [W-1:0] w;
        w = w_in;
        for (int k = 0; k < sida_pkg::STEP_BITS; k++) begin
            for (int d = 0; d < sida_pkg::DIGITS; d++) begin
                if (w[sida_pkg::BIN_W + 4*d +: 4] >= 4'd5) begin
                    w[sida_pkg::BIN_W + 4*d +: 4] = w[sida_pkg::BIN_W + 4*d +: 4] + 4'd3;
                end
            end
            w = {w[W-2:0], 1'b0};
        end
        return w;
    endfunction

    logic [sida_pkg::BIN_W-1:0]   r_bin;
    logic [sida_pkg::BCD_W-1:0]   r_bcd;
    logic [sida_pkg::IDX_W-1:0]   r_idx;
    logic                         r_sign_pend;
    logic                         r_valid;
    logic [sida_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;

    logic [sida_pkg::VALUE_W-1:0] mag;
    logic [W-1:0]                 conv_next;
    logic [sida_pkg::IDX_W-1:0]   top_idx;
    logic [3:0]                   digit;

    assign mag       = i_value[sida_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
    assign conv_next = dd_step({r_bcd, r_bin});
    assign digit     = r_bcd[r_idx*4 +: 4];

    always_comb begin
        top_idx = '0;
        for (int d = 0; d < sida_pkg::DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                top_idx = sida_pkg::IDX_W'(d);
            end
        end
    end

    assign o_status.last = !r_sign_pend && (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin       <= sida_pkg::BIN_W'(mag);
            r_bcd       <= '0;
            r_sign_pend <= i_value[sida_pkg::VALUE_W-1];
        end
        if (i_cmd.conv) begin
            {r_bcd, r_bin} <= conv_next;
        end
        if (i_cmd.measure) begin
            r_idx <= top_idx;
        end
        if (i_cmd.emit) begin
            if (r_sign_pend) begin
                r_char      <= sida_pkg::CH_MINUS;
                r_last      <= 1'b0;
                r_sign_pend <= 1'b0;
            end else begin
                r_char <= sida_pkg::CH_ZERO + {4'd0, digit};
                r_last <= (r_idx == '0);
                r_idx  <= r_idx - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

`ifndef SYNTH
    a_run_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_char) |=> o_valid)
        else $error("character run broken before last beat");
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_char_code == sida_pkg::CH_MINUS)) |-> !o_last_char)
        else $error("minus sign flagged as last character");
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_char_code == sida_pkg::CH_MINUS) ||
                     ((o_char_code >= sida_pkg::CH_ZERO) &&
                      (o_char_code <= sida_pkg::CH_ZERO + 8'd9))))
        else $error("character is neither minus nor a digit");
`endif

endmodule

// File: hw/rtl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top: integer to decimal ASCII text
// Converts one 33-bit two's complement integer into its decimal characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_value and pulse start while busy is low; the beat is taken
//   at that clock edge and busy rises on the next cycle.
//   Output: characters come out most significant first, one per cycle, each
//   marked by o_valid for exactly one cycle. A negative value is led by '-';
//   there are no leading zeros, zero gives "0". o_last_char flags the final
//   beat of a run (1 to 11 characters).
//   Sequence: a load step, the shift-add-3 conversion steps (4 bits per
//   cycle), a step that finds the leading digit, then the characters.
//   The output strobe is registered, so a new start may be taken while the
//   final character of the previous run is still on the ports.
//   The receiver cannot stall: every character must be taken when strobed.
//   Reset (i_rst_n low, synchronous) returns the controller to idle and
//   drops o_valid; any run in progress is abandoned.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [sida_pkg::VALUE_W-1:0] i_value,
    output logic                         o_valid,
    output logic [sida_pkg::CHAR_W-1:0]  o_char_code,
    output logic                         o_last_char
);

    sida_pkg::t_cmd    cmd;
    sida_pkg::t_status status;

    // sequencing
    sida_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // magnitude, BCD conversion, character output register
    sida_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

// File: tb/signed_int_to_decimal_ascii_top_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_tb: self-checking bench for the decimal text converter
// Sends 33-bit two's complement integers on the start/busy command port and
// checks each strobed character, in order, against a predicted text queue.
// It starts with directed boundary values and then runs three random phases
// with different amounts of idle time on the sending side.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top_tb;

    localparam int IDLE_LIMIT   = 2000;   // cycles with no beat moving before giving up
    localparam int DRAIN_CYCLES = 30;     // quiet time after the last expected character
    localparam int MAX_GAP      = 24;     // longest sender gap, spans a whole item
    localparam int PHASE_ITEMS  = 63;     // random items per random phase

    typedef struct packed {
        logic [sida_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_char_beat;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [sida_pkg::VALUE_W-1:0] i_value;
    logic                         o_valid;
    logic [sida_pkg::CHAR_W-1:0]  o_char_code;
    logic                         o_last_char;

    // characters still owed by the block, oldest first
    t_char_beat exp_chars[$];
    int         mismatches = 0;
    int         send_idle_pct = 0;    // chance per item that the sender pauses first
    int         quiet_cycles = 0;

    signed_int_to_decimal_ascii_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    // 2-unit clock period
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Text prediction: sign from bit 32, magnitude at full width, then the
    // digits most significant first. The last character carries the flag.
    // -2147483648 and the values below the signed range need nothing special:
    // the magnitude never exceeds 2^32, so ten digits are always enough.
    // ------------------------------------------------------------------------
    function automatic void push_decimal_text(input logic [sida_pkg::VALUE_W-1:0] v);
        logic [sida_pkg::VALUE_W:0]  mag;
        logic [sida_pkg::CHAR_W-1:0] digs[10];
        int                          nd;
        t_char_beat                  b;
        mag = v[sida_pkg::VALUE_W-1] ? ({1'b1, {sida_pkg::VALUE_W{1'b0}}} - {1'b0, v})
                                     : {1'b0, v};
        nd  = 0;
        do begin
            digs[nd] = sida_pkg::CH_ZERO + sida_pkg::CHAR_W'(mag % 10);
            mag      = mag / 10;
            nd++;
        end while (mag != 0 && nd < 10);
        if (v[sida_pkg::VALUE_W-1]) begin
            b.code = sida_pkg::CH_MINUS;
            b.last = 1'b0;
            exp_chars.push_back(b);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            b.code = digs[k];
            b.last = (k == 0);
            exp_chars.push_back(b);
        end
    endfunction

    // Signed magnitude to the 33-bit port encoding; -0 folds to 0.
    function automatic logic [sida_pkg::VALUE_W-1:0] encode_value(input longint unsigned mag,
                                                                  input bit neg);
        return neg ? sida_pkg::VALUE_W'((64'd1 << sida_pkg::VALUE_W) - mag)
                   : sida_pkg::VALUE_W'(mag);
    endfunction

    // Random value with exactly nd decimal digits in its magnitude.
    function automatic logic [sida_pkg::VALUE_W-1:0] value_with_digits(input int nd,
                                                                       input bit neg);
        longint unsigned lo, hi, mag;
        lo = 1;
        repeat (nd - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (nd == 1) lo = 0;
        // positive side tops out at 2^32-1, negative side at 2^32
        if (neg && hi > 64'd4294967296) hi = 64'd4294967296;
        if (!neg && hi > 64'd4294967295) hi = 64'd4294967295;
        mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
        return encode_value(mag, neg);
    endfunction

    // ------------------------------------------------------------------------
    // One command beat. An optional pause with start low comes first; start
    // then stays high until a rising edge sees busy low. Inputs only move on
    // the falling edge, and each falling edge assigns start once.
    // ------------------------------------------------------------------------
    task automatic send_value(input logic [sida_pkg::VALUE_W-1:0] v);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(MAX_GAP, 1) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        push_decimal_text(v);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_zero_and_single_digits();
        send_value(encode_value(0, 1'b0));
        send_value(encode_value(1, 1'b0));
        send_value(encode_value(1, 1'b1));
        send_value(encode_value(9, 1'b0));
        send_value(encode_value(9, 1'b1));
    endtask

    task automatic test_digit_rollover();
        send_value(encode_value(10, 1'b0));
        send_value(encode_value(10, 1'b1));
        send_value(encode_value(99, 1'b0));
        send_value(encode_value(100, 1'b0));
        send_value(encode_value(999999999, 1'b1));
        send_value(encode_value(1000000000, 1'b0));
        send_value(encode_value(1234567890, 1'b1));
    endtask

    task automatic test_range_extremes();
        send_value(encode_value(64'd2147483647, 1'b0));   // largest signed 32-bit
        send_value(encode_value(64'd2147483648, 1'b1));   // most negative 32-bit
        send_value(encode_value(64'd2147483648, 1'b0));   // unsigned just past int max
        send_value(encode_value(64'd4294967295, 1'b0));   // largest unsigned 32-bit
        send_value(encode_value(64'd4294967294, 1'b0));
        send_value(encode_value(64'd2147483649, 1'b1));   // just below the stated range
        send_value(encode_value(64'd4294967296, 1'b1));   // bottom of the 33-bit range
        send_value(encode_value(64'd4294967295, 1'b1));
        send_value(33'h0_AAAA_AAAA);                      // alternating bit patterns
        send_value(33'h1_5555_5555);
    endtask

    // ------------------------------------------------------------------------
    // Random test: mostly values shaped by digit count, so every run length
    // shows up often, plus raw 33-bit patterns and values around powers of ten.
    // ------------------------------------------------------------------------
    task automatic test_random_values(input int idle_pct, input int count);
        int              pick;
        longint unsigned pow;
        send_idle_pct = idle_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_value(value_with_digits($urandom_range(10, 1), 1'($urandom_range(1))));
            end else if (pick < 80) begin
                send_value(sida_pkg::VALUE_W'({$urandom_range(1), $urandom}));
            end else begin
                pow = 1;
                repeat ($urandom_range(9)) pow = pow * 10;
                send_value(encode_value(pow + $urandom_range(2) - 1, 1'($urandom_range(1))));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Character check: every strobed beat is taken, and must match the oldest
    // predicted character. A beat with nothing predicted is a failure too.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : char_check
        t_char_beat want;
        if (i_rst_n && o_valid) begin
            if (exp_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: char %0d last %0b", o_char_code, o_last_char);
            end else begin
                want = exp_chars.pop_front();
                if (o_char_code !== want.code || o_last_char !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                                 want.code, want.last, o_char_code, o_last_char);
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("signed_int_to_decimal_ascii_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_and_single_digits();
        test_digit_rollover();
        test_range_extremes();
        test_random_values(21, PHASE_ITEMS);
        test_random_values(67, PHASE_ITEMS);
        test_random_values(0, PHASE_ITEMS);

        @(negedge i_clk);
        start <= 1'b0;

        // every predicted character must arrive, then stray beats get a window
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("signed_int_to_decimal_ascii_top test passed");
        else
            $display("signed_int_to_decimal_ascii_top test failed");
        $finish;
    end

endmodule
